FILE: hw/rtl/sla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types and constants for the sliding lagged autocorrelation block.
// ----------------------------------------------------------------------------
package sla_pkg;

  // Sample width and result format
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int FRAC_BITS   = 14;
  localparam int Q_ONE       = 16384;
  localparam int QUOT_BITS   = FRAC_BITS + 1;

  // Configuration port
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 16;
  localparam int REG_BITS      = 9;
  localparam int WINDOW_RESET  = 64;
  localparam int LAG_RESET     = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW_LENGTH = 4'd0,
    CFG_LAG           = 4'd1
  } cfg_reg_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_UPD,
    ST_MUL,
    ST_VAR,
    ST_SQRT,
    ST_DMUL,
    ST_DINIT,
    ST_DIV,
    ST_DONE
  } ctl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic prod;
    logic upd;
    logic mul;
    logic var_calc;
    logic sqrt_step;
    logic dmul;
    logic div_init;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // Number of root iterations for a given maximum window
  function automatic int sqrt_steps(input int max_window);
    int cw;
    int vw;
    cw = $clog2(max_window + 1);
    vw = cw + (2 * SAMPLE_BITS + cw) + 1;
    return ((vw - 1) / 2) + 1;
  endfunction

endpackage

FILE: hw/rtl/sliding_lagged_autocorrelation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_lagged_autocorrelation
// Pearson coefficient of a sliding window of (sample, lagged sample) pairs.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata[15:0] sample
//   m_axis   out        tdata[15:0] coefficient (Q2.14), tuser[0] window_full
//   cfg      in         index 0 window_length, index 1 lag, data[8:0]
//
// Each sample is taken through the sums, products, the two-bit-a-step square
// root and the one-bit-a-step divider before its result is loaded. Reset
// clears sums and the lag line fill mark at once.
// A held result stalls only the final step; a new sample is taken as soon as
// the result register is loaded.
// ----------------------------------------------------------------------------
module sliding_lagged_autocorrelation
  import sla_pkg::*;
#(
  parameter int MAX_WINDOW = 256,
  parameter int MAX_LAG    = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [SAMPLE_BITS-1:0]   s_axis_tdata_i,   // [15:0] sample
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [COEF_BITS-1:0]     m_axis_tdata_o,   // [15:0] coefficient
  output logic                     m_axis_tuser_o,   // [0] window_full
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int SqrtSteps = sqrt_steps(MAX_WINDOW);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  sla_ctrl #(
    .SQRT_STEPS (SqrtSteps),
    .DIV_STEPS  (QUOT_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sla_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_LAG    (MAX_LAG)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sample_i      (s_axis_tdata_i),
    .cfg_write_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .coefficient_o (m_axis_tdata_o),
    .window_full_o (m_axis_tuser_o)
  );

endmodule

FILE: hw/rtl/sla_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_ctrl
// Sequencer for one sample: sums, products, two roots, divide, result.
// ----------------------------------------------------------------------------
module sla_ctrl
  import sla_pkg::*;
#(
  parameter int SQRT_STEPS = 26,
  parameter int DIV_STEPS  = 15
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam int MaxSteps = (SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS;
  localparam int CntW     = $clog2(MaxSteps + 1);

  ctl_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Hold state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) begin
        state_d = ST_PROD;
      end
      ST_PROD:  state_d = ST_UPD;
      ST_UPD:   state_d = ST_MUL;
      ST_MUL:   state_d = ST_VAR;
      ST_VAR: begin
        state_d = ST_SQRT;
        cnt_d   = '0;
      end
      ST_SQRT: begin
        if (cnt_q == CntW'(SQRT_STEPS - 1)) begin
          state_d = ST_DMUL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DMUL:  state_d = ST_DINIT;
      ST_DINIT: begin
        state_d = ST_DIV;
        cnt_d   = '0;
      end
      ST_DIV: begin
        if (cnt_q == CntW'(DIV_STEPS - 1)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE:  if (sts_i.out_free) begin
        state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_PROD:  cmd_o.prod      = 1'b1;
      ST_UPD:   cmd_o.upd       = 1'b1;
      ST_MUL:   cmd_o.mul       = 1'b1;
      ST_VAR:   cmd_o.var_calc  = 1'b1;
      ST_SQRT:  cmd_o.sqrt_step = 1'b1;
      ST_DMUL:  cmd_o.dmul      = 1'b1;
      ST_DINIT: cmd_o.div_init  = 1'b1;
      ST_DIV:   cmd_o.div_step  = 1'b1;
      ST_DONE:  cmd_o.out_load  = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

FILE: hw/rtl/sla_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_datapath
// Lag line, pair ring, running sums, root and divide units, result register.
// ----------------------------------------------------------------------------
module sla_datapath
  import sla_pkg::*;
#(
  parameter int MAX_WINDOW = 256,
  parameter int MAX_LAG    = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic                     cfg_write_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [COEF_BITS-1:0]     coefficient_o,
  output logic                     window_full_o
);

  localparam int SB      = SAMPLE_BITS;
  localparam int CW      = $clog2(MAX_WINDOW + 1);
  localparam int RPW     = $clog2(MAX_WINDOW);
  localparam int LAW     = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
  localparam int IW      = LAW + 2 + REG_BITS;
  localparam int SXW     = SB + CW;
  localparam int QW      = 2 * SB + CW;
  localparam int VW      = CW + QW + 1;
  localparam int RW      = (VW + 1) / 2;
  localparam int DW      = 2 * RW;
  localparam int RMW     = DW + 2;
  localparam int NUMW    = RMW + QUOT_BITS;
  localparam int BIT_TOP = ((VW - 1) / 2) * 2;

  // --------------------------------------------------------------------------
  // Configuration registers
  logic [REG_BITS-1:0] window_length_q, lag_q;
  logic                restart;

  assign restart = cfg_write_i &&
                   (cfg_index_i == CFG_WINDOW_LENGTH || cfg_index_i == CFG_LAG);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= REG_BITS'(WINDOW_RESET);
      lag_q           <= REG_BITS'(LAG_RESET);
    end else if (cfg_write_i) begin
      if (cfg_index_i == CFG_WINDOW_LENGTH) begin
        window_length_q <= cfg_data_i[REG_BITS-1:0];
      end
      if (cfg_index_i == CFG_LAG) begin
        lag_q <= cfg_data_i[REG_BITS-1:0];
      end
    end
  end

  // Effective window and lag
  logic [CW-1:0]  win;
  logic [IW-1:0]  lag_eff;
  always_comb begin
    if (window_length_q == '0) begin
      win = CW'(1);
    end else if (32'(window_length_q) > 32'(MAX_WINDOW)) begin
      win = CW'(MAX_WINDOW);
    end else begin
      win = CW'(window_length_q);
    end
    if (32'(lag_q) > 32'(MAX_LAG)) begin
      lag_eff = IW'(MAX_LAG);
    end else begin
      lag_eff = IW'(lag_q);
    end
  end

  // --------------------------------------------------------------------------
  // Lag line: written in order, so a fill mark tells which entries hold data
  logic [SB-1:0]  lag_mem [MAX_LAG];
  logic [LAW-1:0] lag_pos_q;
  logic           lag_wrapped_q;
  logic [SB-1:0]  lag_rd_q;
  logic           lag_hit_q;
  logic [LAW-1:0] lag_idx;
  logic [IW-1:0]  lag_pos_w;

  assign lag_pos_w = IW'(lag_pos_q);

  always_comb begin
    if (lag_pos_w >= lag_eff) begin
      lag_idx = LAW'(lag_pos_w - lag_eff);
    end else begin
      lag_idx = LAW'(lag_pos_w + IW'(MAX_LAG) - lag_eff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_pos_q     <= '0;
      lag_wrapped_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (32'(lag_pos_q) == MAX_LAG - 1) begin
        lag_pos_q     <= '0;
        lag_wrapped_q <= 1'b1;
      end else begin
        lag_pos_q <= lag_pos_q + 1'b1;
      end
    end
  end

  // Read the old entry before the new sample lands
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lag_rd_q          <= lag_mem[lag_idx];
      lag_hit_q         <= lag_wrapped_q || (lag_idx < lag_pos_q);
      lag_mem[lag_pos_q] <= sample_i;
    end
  end

  // --------------------------------------------------------------------------
  // Pair ring
  logic [2*SB-1:0] ring_mem [MAX_WINDOW];
  logic [2*SB-1:0] ring_rd_q;
  logic [RPW-1:0]  ring_pos_q, ring_pos_d;
  logic [RPW-1:0]  rp_q, rp;
  logic [CW-1:0]   pair_count_q, pair_count_d;

  assign rp = (CW'(ring_pos_q) >= win) ? '0 : ring_pos_q;

  logic signed [SB-1:0] x_q, y_cur, y_q, ox_q, oy_q;
  logic                 drop_q;

  assign y_cur = (lag_eff == '0) ? x_q : (lag_hit_q ? lag_rd_q : '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ring_rd_q <= ring_mem[rp];
    end
    if (cmd_i.prod) begin
      ring_mem[rp_q] <= {y_cur, x_q};
    end
  end

  // --------------------------------------------------------------------------
  // Capture sample, form the six small products
  logic signed [2*SB-1:0] p_xx_q, p_yy_q, p_xy_q, p_oxx_q, p_oyy_q, p_oxy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q  <= sample_i;
      rp_q <= rp;
    end
    if (cmd_i.prod) begin
      y_q     <= y_cur;
      ox_q    <= ring_rd_q[SB-1:0];
      oy_q    <= ring_rd_q[2*SB-1:SB];
      drop_q  <= (pair_count_q >= win);
      p_xx_q  <= x_q * x_q;
      p_yy_q  <= y_cur * y_cur;
      p_xy_q  <= x_q * y_cur;
      p_oxx_q <= $signed(ring_rd_q[SB-1:0]) * $signed(ring_rd_q[SB-1:0]);
      p_oyy_q <= $signed(ring_rd_q[2*SB-1:SB]) * $signed(ring_rd_q[2*SB-1:SB]);
      p_oxy_q <= $signed(ring_rd_q[SB-1:0]) * $signed(ring_rd_q[2*SB-1:SB]);
    end
  end

  // --------------------------------------------------------------------------
  // Running sums: add the new pair, drop the oldest once the window is full
  logic signed [SXW-1:0] sum_x_q, sum_y_q, sum_x_d, sum_y_d;
  logic signed [QW-1:0]  sum_xx_q, sum_yy_q, sum_xy_q, sum_xx_d, sum_yy_d, sum_xy_d;

  always_comb begin
    sum_x_d      = sum_x_q + SXW'(x_q);
    sum_y_d      = sum_y_q + SXW'(y_q);
    sum_xx_d     = sum_xx_q + QW'(p_xx_q);
    sum_yy_d     = sum_yy_q + QW'(p_yy_q);
    sum_xy_d     = sum_xy_q + QW'(p_xy_q);
    pair_count_d = pair_count_q;
    if (drop_q) begin
      sum_x_d  = sum_x_d - SXW'(ox_q);
      sum_y_d  = sum_y_d - SXW'(oy_q);
      sum_xx_d = sum_xx_d - QW'(p_oxx_q);
      sum_yy_d = sum_yy_d - QW'(p_oyy_q);
      sum_xy_d = sum_xy_d - QW'(p_oxy_q);
    end else begin
      pair_count_d = pair_count_q + 1'b1;
    end
    if (CW'(rp_q) + 1'b1 >= win) begin
      ring_pos_d = '0;
    end else begin
      ring_pos_d = rp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      sum_xx_q     <= '0;
      sum_yy_q     <= '0;
      sum_xy_q     <= '0;
      pair_count_q <= '0;
      ring_pos_q   <= '0;
    end else if (restart) begin
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      sum_xx_q     <= '0;
      sum_yy_q     <= '0;
      sum_xy_q     <= '0;
      pair_count_q <= '0;
      ring_pos_q   <= '0;
    end else if (cmd_i.upd) begin
      sum_x_q      <= sum_x_d;
      sum_y_q      <= sum_y_d;
      sum_xx_q     <= sum_xx_d;
      sum_yy_q     <= sum_yy_d;
      sum_xy_q     <= sum_xy_d;
      pair_count_q <= pair_count_d;
      ring_pos_q   <= ring_pos_d;
    end
  end

  // --------------------------------------------------------------------------
  // Wide products for the variance and covariance terms
  logic signed [VW-1:0]    m_nxx_q, m_nyy_q, m_nxy_q;
  logic signed [2*SXW-1:0] m_xx_q, m_yy_q, m_xsy_q;
  logic signed [CW:0]      n_s;

  assign n_s = $signed({1'b0, pair_count_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      m_nxx_q <= n_s * sum_xx_q;
      m_nyy_q <= n_s * sum_yy_q;
      m_nxy_q <= n_s * sum_xy_q;
      m_xx_q  <= sum_x_q * sum_x_q;
      m_yy_q  <= sum_y_q * sum_y_q;
      m_xsy_q <= sum_x_q * sum_y_q;
    end
  end

  // Variance terms clamped at zero, covariance magnitude and sign
  logic signed [VW-1:0] vx, vy, cv;
  logic [VW-1:0]        mag_q;
  logic                 neg_q;

  assign vx = m_nxx_q - VW'(m_xx_q);
  assign vy = m_nyy_q - VW'(m_yy_q);
  assign cv = m_nxy_q - VW'(m_xsy_q);

  // --------------------------------------------------------------------------
  // Two integer square roots, two radicand bits per lane each step
  logic [1:0][VW-1:0] sv_q, sr_q, sv_d, sr_d;
  logic [VW-1:0]      sbit_q;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (sv_q[i] >= sr_q[i] + sbit_q) begin
        sv_d[i] = sv_q[i] - (sr_q[i] + sbit_q);
        sr_d[i] = (sr_q[i] >> 1) + sbit_q;
      end else begin
        sv_d[i] = sv_q[i];
        sr_d[i] = sr_q[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.var_calc) begin
      sv_q[0] <= vx[VW-1] ? '0 : vx;
      sv_q[1] <= vy[VW-1] ? '0 : vy;
      sr_q    <= '0;
      sbit_q  <= VW'(1) << BIT_TOP;
      mag_q   <= cv[VW-1] ? VW'(-cv) : VW'(cv);
      neg_q   <= cv[VW-1];
    end else if (cmd_i.sqrt_step) begin
      sv_q   <= sv_d;
      sr_q   <= sr_d;
      sbit_q <= sbit_q >> 2;
    end
  end

  // --------------------------------------------------------------------------
  // Denominator, then restoring divide with half-up rounding
  logic [DW-1:0]        den_q;
  logic [NUMW-1:0]      num;
  logic [RMW-1:0]       rem_q, rem_sh;
  logic [QUOT_BITS-1:0] low_q, quot_q;
  logic                 force_one_q, force_zero_q;

  assign num = (NUMW'(mag_q) << FRAC_BITS) + NUMW'(den_q >> 1);
  assign rem_sh = {rem_q[RMW-2:0], low_q[QUOT_BITS-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.dmul) begin
      den_q <= sr_q[0][RW-1:0] * sr_q[1][RW-1:0];
    end
    if (cmd_i.div_init) begin
      rem_q        <= num[NUMW-1:QUOT_BITS];
      low_q        <= num[QUOT_BITS-1:0];
      quot_q       <= '0;
      force_zero_q <= (pair_count_q != CW'(1)) && (den_q == '0);
      force_one_q  <= (pair_count_q == CW'(1)) ||
                      ((den_q != '0) && (VW'(mag_q) >= den_q));
    end else if (cmd_i.div_step) begin
      low_q <= low_q << 1;
      if (rem_sh >= RMW'(den_q)) begin
        rem_q  <= rem_sh - RMW'(den_q);
        quot_q <= {quot_q[QUOT_BITS-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        quot_q <= {quot_q[QUOT_BITS-2:0], 1'b0};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  logic [QUOT_BITS-1:0] q_mag;
  logic [COEF_BITS-1:0] coef_d;
  logic                 out_valid_q;
  logic [COEF_BITS-1:0] coef_q;
  logic                 full_q;

  always_comb begin
    priority if (force_zero_q) begin
      q_mag = '0;
    end else if (force_one_q || (quot_q > QUOT_BITS'(Q_ONE))) begin
      q_mag = QUOT_BITS'(Q_ONE);
    end else begin
      q_mag = quot_q;
    end
    coef_d = (neg_q && !(pair_count_q == CW'(1))) ? COEF_BITS'(-COEF_BITS'(q_mag))
                                                 : COEF_BITS'(q_mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      coef_q <= coef_d;
      full_q <= (pair_count_q >= win);
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign coefficient_o  = coef_q;
  assign window_full_o  = full_q;

endmodule
